@@ src/csi64_pkg.sv @@
// ----------------------------------------------------------------------------
// Signed 64-bit ALU package
// Operation and status codes, payload types and stage constants.
// ----------------------------------------------------------------------------
package csi64_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_REM = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_BAD_OP   = 2'd2
  } status_e;

  localparam int unsigned DataW   = 64;
  localparam int unsigned DivBits = 4;                  // quotient bits per stage
  localparam int unsigned DivStgs = DataW / DivBits;    // radix-2 steps grouped

  // Per-stage payload.
  typedef struct packed {
    logic [2:0]       kind;
    logic [DataW-1:0] rem;     // partial remainder
    logic [DataW-1:0] quo;     // dividend shifting out / quotient shifting in
    logic [DataW-1:0] dvs;     // divisor magnitude
    logic             neg_q;
    logic             neg_r;
    logic [DataW-1:0] res;     // finished result for non-divide ops
    logic [1:0]       status;
  } stage_t;

endpackage

@@ src/checked_signed_int64_alu.sv @@
// ----------------------------------------------------------------------------
// Checked signed 64-bit ALU
// Add, subtract, multiply, divide and remainder on signed 64-bit operands.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_axis (tdata: kind, left_operand, right_operand);
//   one result item per input leaves on m_axis (tdata: value, status).
//   Every operation goes through the same pipeline of 18 register stages:
//   one stage takes operand magnitudes and three 32x32 partial products,
//   sixteen stages each retire four bits of the restoring divider (the
//   longest chain, which sets the depth), one stage fixes up signs.
//   Throughput is one item per cycle while m_axis does not stall.
//   Multiply sums its partial products in the stage after they are made.
//   A stall on m_axis freezes the whole pipeline in place; s_axis_tready
//   is high whenever the last stage is empty or is being taken, so a bubble
//   never blocks the input. Reset empties every stage; the payload is left
//   as it was. Results are in acceptance order.
// ----------------------------------------------------------------------------
module checked_signed_int64_alu (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: [2:0] kind, [66:3] left_operand, [130:67] right_operand, zero fill
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: [63:0] value, [65:64] status, zero fill
  output logic [71:0]  m_axis_tdata
);
  import csi64_pkg::*;

  logic             adv;
  logic [2:0]       in_kind;
  logic [DataW-1:0] in_a, in_b, mag_a, mag_b;
  logic [DataW-1:0] in_res;
  status_e          in_st;

  stage_t            s0_q;
  logic              v0_q;
  logic [DataW-1:0]  pll_q, plh_q, phl_q;   // partial products
  stage_t            sd_q [DivStgs];
  logic              vd_q [DivStgs];
  stage_t            st_d [DivStgs];
  logic [DataW-1:0]  out_val_q;
  logic [1:0]        out_st_q;
  logic              out_v_q;

  assign adv = !out_v_q || m_axis_tready;
  assign s_axis_tready = adv;

  assign in_kind = s_axis_tdata[2:0];
  assign in_a    = s_axis_tdata[66:3];
  assign in_b    = s_axis_tdata[130:67];
  assign mag_a   = in_a[DataW-1] ? (~in_a + 64'd1) : in_a;
  assign mag_b   = in_b[DataW-1] ? (~in_b + 64'd1) : in_b;

  // Decode: add/sub result and status for the incoming item.
  always_comb begin
    in_res = '0;
    in_st  = ST_OK;
    case (in_kind)
      OP_ADD: in_res = in_a + in_b;
      OP_SUB: in_res = in_a - in_b;
      OP_MUL: in_res = '0;
      OP_DIV, OP_REM: begin
        if (in_b == '0) in_st = ST_DIV_ZERO;
      end
      default: in_st = ST_BAD_OP;
    endcase
  end

  // Stage 0: decode, magnitudes, add/sub, partial products.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_q.kind   <= in_kind;
      s0_q.rem    <= '0;
      s0_q.quo    <= mag_a;
      s0_q.dvs    <= mag_b;
      s0_q.neg_q  <= in_a[DataW-1] ^ in_b[DataW-1];
      s0_q.neg_r  <= in_a[DataW-1];
      s0_q.status <= in_st;
      s0_q.res    <= in_res;
      pll_q <= in_a[31:0] * in_b[31:0];
      plh_q <= in_a[31:0] * in_b[63:32];
      phl_q <= in_a[63:32] * in_b[31:0];
    end
  end

  // Divider stages, four restoring steps each. Stage 0 of the chain also
  // sums the multiply partial products into the result field.
  for (genvar g = 0; g < DivStgs; g++) begin : g_div
    stage_t src;
    if (g == 0) begin : g_first
      always_comb begin
        src = s0_q;
        if (s0_q.kind == OP_MUL) begin
          src.res = pll_q + {plh_q[31:0] + phl_q[31:0], 32'd0};
        end
      end
    end else begin : g_rest
      assign src = sd_q[g-1];
    end

    always_comb begin
      logic [DataW:0] trial;
      st_d[g] = src;
      for (int k = 0; k < DivBits; k++) begin
        trial = {st_d[g].rem, st_d[g].quo[DataW-1]} - {1'b0, st_d[g].dvs};
        if (!trial[DataW]) begin
          st_d[g].rem = trial[DataW-1:0];
          st_d[g].quo = {st_d[g].quo[DataW-2:0], 1'b1};
        end else begin
          st_d[g].rem = {st_d[g].rem[DataW-2:0], st_d[g].quo[DataW-1]};
          st_d[g].quo = {st_d[g].quo[DataW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vd_q[g] <= 1'b0;
      end else if (adv) begin
        vd_q[g] <= (g == 0) ? v0_q : vd_q[(g == 0) ? 0 : g-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) sd_q[g] <= st_d[g];
    end
  end

  // Final stage: sign fix-up and status masking.
  stage_t           last;
  logic [DataW-1:0] fin_val;
  assign last = sd_q[DivStgs-1];

  always_comb begin
    fin_val = '0;
    if (last.status == ST_OK) begin
      case (last.kind)
        OP_DIV:  fin_val = last.neg_q ? (~last.quo + 64'd1) : last.quo;
        OP_REM:  fin_val = last.neg_r ? (~last.rem + 64'd1) : last.rem;
        default: fin_val = last.res;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= vd_q[DivStgs-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_val_q <= fin_val;
      out_st_q  <= last.status;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {6'd0, out_st_q, out_val_q};

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !m_axis_tready |=> out_v_q && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Non-ok status always comes with zero value.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_st_q != ST_OK |-> out_val_q == '0)
    else $error("non-zero value with error status");

  // Bad codes never report ok.
  a_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v0_q && (s0_q.kind > OP_REM) |-> s0_q.status == ST_BAD_OP)
    else $error("bad code not flagged");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed 64-bit ALU testbench
// Streams operations into the ALU under random source and sink gaps and
// compares every result item against a software prediction, in order.
// ----------------------------------------------------------------------------
module tb_top;
  import csi64_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] lhs;
    logic [63:0] rhs;
  } alu_op_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
  } alu_res_t;

  localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxVal = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] AllOne = 64'hffff_ffff_ffff_ffff;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [71:0]  m_axis_tdata;

  alu_op_t  pending_ops[$];
  alu_res_t expected_results[$];
  int       send_idle_pct;
  int       recv_idle_pct;
  bit       hold_sender;
  int       error_count;

  checked_signed_int64_alu uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [63:0] abs64(logic [63:0] x);
    return x[63] ? -x : x;
  endfunction

  function automatic alu_res_t compute_alu(alu_op_t op);
    alu_res_t r;
    logic [63:0] mag;
    r.value  = '0;
    r.status = ST_OK;
    case (op.kind)
      OP_ADD: r.value = op.lhs + op.rhs;
      OP_SUB: r.value = op.lhs - op.rhs;
      OP_MUL: r.value = op.lhs * op.rhs;
      OP_DIV, OP_REM: begin
        if (op.rhs == '0) begin
          r.status = ST_DIV_ZERO;
        end else if (op.kind == OP_DIV) begin
          mag = abs64(op.lhs) / abs64(op.rhs);
          r.value = (op.lhs[63] != op.rhs[63]) ? -mag : mag;
        end else begin
          mag = abs64(op.lhs) % abs64(op.rhs);
          r.value = op.lhs[63] ? -mag : mag;
        end
      end
      default: r.status = ST_BAD_OP;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    error_count++;
  endtask

  // Driver: loads the next item once the current one is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_ops.size() > 0 && !hold_sender &&
            $urandom_range(99) >= send_idle_pct) begin
          alu_op_t op;
          op = pending_ops.pop_front();
          expected_results.push_back(compute_alu(op));
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {5'b0, op.rhs, op.lhs, op.kind};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result item and picks the next stall decision.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected item", m_axis_tdata[63:0], '0);
        end else begin
          alu_res_t want;
          want = expected_results.pop_front();
          if (m_axis_tdata[63:0] !== want.value)
            report_mismatch("value", m_axis_tdata[63:0], want.value);
          if (m_axis_tdata[65:64] !== want.status)
            report_mismatch("status", {62'b0, m_axis_tdata[65:64]}, {62'b0, want.status});
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Operands biased toward corners and small values so that the divider
  // sees short quotients, zero divisors and the overflow case often.
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(9))
      0: return MinVal;
      1: return AllOne;
      2: return MaxVal;
      3: return '0;
      4: return 64'($signed($urandom_range(20)) - 10);
      5: return {{32{1'b0}}, $urandom()};
      6: return rand64() >> $urandom_range(63);
      default: return rand64();
    endcase
  endfunction

  task automatic queue_op(logic [2:0] kind, logic [63:0] lhs, logic [63:0] rhs);
    pending_ops.push_back('{kind: kind, lhs: lhs, rhs: rhs});
  endtask

  task automatic drain();
    while (pending_ops.size() > 0 || expected_results.size() > 0 || s_axis_tvalid)
      @(posedge clk_i);
  endtask

  initial begin
    logic [63:0] a;
    logic [63:0] b;
    error_count   = 0;
    send_idle_pct = 13;
    recv_idle_pct = 53;
    hold_sender   = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;

    // Directed: wrap-around, every operation, zero divisor, overflow divide,
    // sign rules of divide and remainder, and the invalid codes.
    queue_op(OP_ADD, MaxVal, 64'd1);
    queue_op(OP_ADD, AllOne, AllOne);
    queue_op(OP_SUB, MinVal, 64'd1);
    queue_op(OP_SUB, '0, MinVal);
    queue_op(OP_MUL, MaxVal, MaxVal);
    queue_op(OP_MUL, MinVal, AllOne);
    queue_op(OP_MUL, AllOne, AllOne);
    queue_op(OP_DIV, MinVal, AllOne);
    queue_op(OP_REM, MinVal, AllOne);
    queue_op(OP_DIV, MaxVal, '0);
    queue_op(OP_REM, MinVal, '0);
    queue_op(OP_DIV, -64'sd7, 64'd2);
    queue_op(OP_REM, -64'sd7, 64'd2);
    queue_op(OP_DIV, 64'd7, -64'sd2);
    queue_op(OP_REM, 64'd7, -64'sd2);
    queue_op(OP_DIV, MinVal, MaxVal);
    queue_op(OP_REM, MaxVal, MinVal);
    queue_op(3'd5, AllOne, AllOne);
    queue_op(3'd6, MaxVal, MinVal);
    queue_op(3'd7, '0, '0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < 1950; i++) begin
      if (i == 650) begin
        drain();
        send_idle_pct = 53;
        recv_idle_pct = 13;
      end else if (i == 1300) begin
        // Hold the queued items back until every result in flight is out.
        hold_sender = 1'b1;
        while (expected_results.size() > 0 || s_axis_tvalid)
          @(posedge clk_i);
        hold_sender   = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      a = pick_operand();
      b = pick_operand();
      queue_op(3'($urandom_range(7)), a, b);
      if (pending_ops.size() > 40) @(posedge clk_i);
    end
    drain();
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
